FILE: hdl/assert_macros.svh
// Assertion macros shared by the step counter modules.
// Depends on nothing; included by the controller and the datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define AMSC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AMSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/amsc_pkg.sv
// Types and constants of the acceleration magnitude step counter.
// Used by the controller, datapath and top level.
`default_nettype none

package amsc_pkg;

    localparam int ACCEL_W   = 12;
    localparam int THR_W     = 12;
    localparam int COOL_W    = 8;
    localparam int TOTAL_W   = 32;
    localparam int MAG_W     = 12;
    localparam int RAD_W     = 24;   // sum of three squares of 12-bit values
    localparam int REM_W     = 15;
    localparam int CNT_W     = 4;

    localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(2);   // three axes
    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(11);  // twelve root digits

    localparam logic [THR_W-1:0]  HIGH_THR_RESET = THR_W'(1150);
    localparam logic [THR_W-1:0]  LOW_THR_RESET  = THR_W'(1050);
    localparam logic [COOL_W-1:0] COOLDOWN_RESET = COOL_W'(15);

    typedef enum logic [1:0] {
        CFG_HIGH_THR = 2'd0,
        CFG_LOW_THR  = 2'd1,
        CFG_COOLDOWN = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic signed [ACCEL_W-1:0] accel_x;
        logic signed [ACCEL_W-1:0] accel_y;
        logic signed [ACCEL_W-1:0] accel_z;
    } t_sample;

    typedef struct packed {
        logic               step_detected;
        logic [TOTAL_W-1:0] total_steps;
        logic [MAG_W-1:0]   smoothed_magnitude;
    } t_result;

    typedef struct packed {
        logic [1:0]       index;
        logic [THR_W-1:0] data;
    } t_cfg_word;

    typedef struct packed {
        logic       load;       // capture the sample, clear the accumulator
        logic       square;     // add the square of one axis
        logic [1:0] axis;       // axis for the square step
        logic       root_step;  // one digit of the square root
        logic       commit;     // update filter and step state, write result word
    } t_ctrl_cmd;

endpackage

`default_nettype wire

FILE: hdl/amsc_stream_if.sv
// Valid/ready channel carrying one payload word of a given type.
// Depends on nothing; the payload types come from amsc_pkg.
`default_nettype none

interface amsc_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hdl/amsc_ctrl.sv
// Sequencing state machine of the step counter.
// Depends on amsc_pkg; drives the datapath through t_ctrl_cmd.
`default_nettype none
`include "assert_macros.svh"

module amsc_ctrl
    import amsc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_ctrl_cmd o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SQUARE = 4'b0010,
        ST_ROOT   = 4'b0100,
        ST_UPDATE = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SQUARE;
                    n_count    = '0;
                end
            end
            ST_SQUARE: begin
                o_cmd.square = 1'b1;
                o_cmd.axis   = r_count[1:0];
                if (r_count == SQ_LAST) begin
                    n_state = ST_ROOT;
                    n_count = '0;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (r_count == ROOT_LAST) begin
                    n_state = ST_UPDATE;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            ST_UPDATE: begin
                // The result register must be free before the state moves on.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `AMSC_ASSERT_NEXT(a_accept_starts_square, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == ST_SQUARE && r_count == '0, "accepted word did not start the square phase")
    `AMSC_ASSERT(a_commit_free_slot, i_clk, i_rst_n, !o_cmd.commit || !r_out_valid || i_out_ready, "commit would overwrite a pending result word")
    `AMSC_ASSERT_NEXT(a_commit_shows_result, i_clk, i_rst_n, o_cmd.commit, r_out_valid && r_state == ST_IDLE, "commit did not present a result word")

endmodule

`default_nettype wire

FILE: hdl/amsc_datapath.sv
// Datapath: sum of squares, digit-by-digit square root, smoothing filter,
// peak hysteresis and step count. Depends on amsc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module amsc_datapath
    import amsc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_ctrl_cmd i_cmd,
    input  wire t_sample   i_sample,
    input  wire logic      i_cfg_valid,
    input  wire t_cfg_word i_cfg,
    output t_result        o_result
);

    // Configuration registers.
    logic [THR_W-1:0]  r_high_thr, r_low_thr;
    logic [COOL_W-1:0] r_cool_len;

    // Working registers of one sample.
    t_sample           r_sample;
    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [MAG_W-1:0]  r_root;

    // Persistent step state.
    logic               r_seeded;
    logic [MAG_W-1:0]   r_filter;
    logic [COOL_W-1:0]  r_cool_left;
    logic               r_armed;
    logic [TOTAL_W-1:0] r_step_total;
    t_result            r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_thr <= HIGH_THR_RESET;
            r_low_thr  <= LOW_THR_RESET;
            r_cool_len <= COOLDOWN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg.index)
                CFG_HIGH_THR: r_high_thr <= i_cfg.data;
                CFG_LOW_THR:  r_low_thr  <= i_cfg.data;
                CFG_COOLDOWN: r_cool_len <= i_cfg.data[COOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // One shared multiplier squares the three axes in turn.
    logic signed [ACCEL_W-1:0]   sq_op;
    logic signed [2*ACCEL_W-1:0] sq_prod;

    always_comb begin
        case (i_cmd.axis)
            2'd0:    sq_op = r_sample.accel_x;
            2'd1:    sq_op = r_sample.accel_y;
            2'd2:    sq_op = r_sample.accel_z;
            default: sq_op = '0;
        endcase
        sq_prod = sq_op * sq_op;
    end

    // One root digit per cycle: the remainder takes the next two radicand bits.
    logic [REM_W-1:0] rem_sh, trial, rem_diff;
    logic             digit;

    always_comb begin
        rem_sh   = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        trial    = {1'b0, r_root, 2'b01};
        digit    = (rem_sh >= trial);
        rem_diff = rem_sh - trial;
    end

    // Rounding, filter and hysteresis applied at commit.
    logic [MAG_W:0]     mag_sum;
    logic [MAG_W-1:0]   mag;
    logic [MAG_W+1:0]   filt_sum;
    logic [MAG_W-1:0]   filt_new;
    logic [COOL_W-1:0]  cool_dec;
    logic               n_seeded, n_armed, det;
    logic [MAG_W-1:0]   n_filter;
    logic [COOL_W-1:0]  n_cool_left;
    logic [TOTAL_W-1:0] n_step_total;

    always_comb begin
        // Rounds up when the remainder exceeds the root; an exact half cannot occur.
        mag_sum  = {1'b0, r_root} + {{MAG_W{1'b0}}, (r_rem > {3'b000, r_root})};
        mag      = mag_sum[MAG_W-1:0];
        filt_sum = {1'b0, r_filter, 1'b0} + {2'b00, r_filter} + {2'b00, mag};
        filt_new = filt_sum[MAG_W+1:2];
        cool_dec = (r_cool_left != '0) ? r_cool_left - 1'b1 : r_cool_left;

        n_seeded     = 1'b1;
        n_filter     = filt_new;
        n_cool_left  = cool_dec;
        n_armed      = r_armed;
        n_step_total = r_step_total;
        det          = 1'b0;
        if (!r_seeded) begin
            n_filter    = mag;
            n_cool_left = r_cool_left;
        end else if (!r_armed) begin
            if (cool_dec == '0 && filt_new >= r_high_thr) begin
                n_armed = 1'b1;
            end
        end else if (filt_new <= r_low_thr) begin
            n_armed      = 1'b0;
            n_cool_left  = r_cool_len;
            n_step_total = r_step_total + 1'b1;
            det          = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
            r_rad    <= '0;
        end else if (i_cmd.square) begin
            r_rad <= r_rad + {1'b0, sq_prod[RAD_W-2:0]};
        end else if (i_cmd.root_step) begin
            r_rad <= {r_rad[RAD_W-3:0], 2'b00};
        end
        if (i_cmd.commit) begin
            r_out.step_detected      <= det;
            r_out.total_steps        <= n_step_total;
            r_out.smoothed_magnitude <= n_filter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.load) begin
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            r_rem  <= digit ? rem_diff : rem_sh;
            r_root <= {r_root[MAG_W-2:0], digit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded     <= 1'b0;
            r_filter     <= '0;
            r_cool_left  <= '0;
            r_armed      <= 1'b0;
            r_step_total <= '0;
        end else if (i_cmd.commit) begin
            r_seeded     <= n_seeded;
            r_filter     <= n_filter;
            r_cool_left  <= n_cool_left;
            r_armed      <= n_armed;
            r_step_total <= n_step_total;
        end
    end

    assign o_result = r_out;

    `AMSC_ASSERT(a_root_rem_bound, i_clk, i_rst_n, r_rem <= {2'b00, r_root, 1'b0}, "root remainder exceeds twice the partial root")
    `AMSC_ASSERT_NEXT(a_total_tracks_step, i_clk, i_rst_n, i_cmd.commit, r_step_total == $past(r_step_total) + {{(TOTAL_W-1){1'b0}}, r_out.step_detected}, "step total does not follow the step flag")

endmodule

`default_nettype wire

FILE: hdl/accel_magnitude_step_counter_top.sv
// Each sample passes in order through the accept cycle in idle, the shared squaring
// multiplier, the one-digit-per-cycle square root and the commit; the next sample is
// taken only once idle again. A new sample is taken while the previous result word still
// waits; a stalled output holds the next sample at its commit, and then the input stalls
// too. Reset (synchronous, active low) restores register defaults and clears the control,
// root and step state; the sample, radicand and result word registers are not reset.
`default_nettype none

module accel_magnitude_step_counter_top
    import amsc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    amsc_stream_if.sink   i_sample,
    amsc_stream_if.source o_result,
    amsc_stream_if.sink   i_cfg
);

    t_ctrl_cmd cmd;

    assign i_cfg.ready = 1'b1;

    amsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample.valid),
        .o_in_ready  (i_sample.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (cmd)
    );

    amsc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_sample    (i_sample.payload),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg       (i_cfg.payload),
        .o_result    (o_result.payload)
    );

endmodule

`default_nettype wire
